/* hw/rtl/fprt_pkg.sv */
package fprt_pkg;

  localparam int INT_BITS_DEF    = 32;
  localparam int FRAC_BITS_DEF   = 32;
  localparam int FRAC_DIGITS_DEF = 3;

  // Bits of the dividend retired per cycle by the integer divider.
  localparam int DIV_STEP    = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] DIGIT_TEN = 6'd10;

  localparam logic [6:0] CHR_ZERO     = 7'd48;
  localparam logic [6:0] CHR_LETTER_A = 7'd65;
  localparam logic [6:0] CHR_POINT    = 7'd46;

  typedef struct packed {
    logic [31:0] value_int;
    logic [31:0] value_frac;
    logic [5:0]  radix;
  } in_item_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       last_char;
  } out_item_t;

  function automatic logic [6:0] digit_code(input logic [5:0] d);
    logic [6:0] code;
    if (d < DIGIT_TEN) begin
      code = CHR_ZERO + {1'b0, d};
    end else begin
      code = CHR_LETTER_A + {1'b0, d - DIGIT_TEN};
    end
    return code;
  endfunction

endpackage

/* hw/rtl/fprt_front.sv */
module fprt_front #(
  parameter int INT_BITS  = fprt_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS = fprt_pkg::FRAC_BITS_DEF
) (
  input  fprt_pkg::in_item_t in_data,
  output logic [$clog2((INT_BITS + fprt_pkg::DIV_STEP - 1) / fprt_pkg::DIV_STEP + 1) + 6
                + FRAC_BITS + ((INT_BITS + fprt_pkg::DIV_STEP - 1) / fprt_pkg::DIV_STEP)
                * fprt_pkg::DIV_STEP - 1:0] job
);

  localparam int NCH  = (INT_BITS + fprt_pkg::DIV_STEP - 1) / fprt_pkg::DIV_STEP;
  localparam int PADW = NCH * fprt_pkg::DIV_STEP;
  localparam int NCW  = $clog2(NCH + 1);

  logic [PADW-1:0]      ip;
  logic [FRAC_BITS-1:0] fp;
  logic [5:0]           r;
  logic [NCW-1:0]       nch;

  // Masks the fields, clamps the radix and finds the number of significant
  // dividend chunks so the divider can skip leading zero bytes.
  always_comb begin
    ip = PADW'(INT_BITS'(in_data.value_int));
    fp = FRAC_BITS'(in_data.value_frac);
    if (in_data.radix < fprt_pkg::RADIX_MIN) begin
      r = fprt_pkg::RADIX_MIN;
    end else if (in_data.radix > fprt_pkg::RADIX_MAX) begin
      r = fprt_pkg::RADIX_MAX;
    end else begin
      r = in_data.radix;
    end
    nch = NCW'(1);
    for (int i = 1; i < NCH; i++) begin
      if (ip[i*fprt_pkg::DIV_STEP +: fprt_pkg::DIV_STEP] != '0) begin
        nch = NCW'(i + 1);
      end
    end
    job = {nch, r, fp, ip};
  end

endmodule

/* hw/rtl/fprt_queue.sv */
module fprt_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int DEPTH = fprt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [W-1:0]  data_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = data_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      data_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

/* hw/rtl/fprt_back.sv */
module fprt_back #(
  parameter int INT_BITS    = fprt_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS   = fprt_pkg::FRAC_BITS_DEF,
  parameter int FRAC_DIGITS = fprt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  logic [$clog2((INT_BITS + fprt_pkg::DIV_STEP - 1) / fprt_pkg::DIV_STEP + 1) + 6
                + FRAC_BITS + ((INT_BITS + fprt_pkg::DIV_STEP - 1) / fprt_pkg::DIV_STEP)
                * fprt_pkg::DIV_STEP - 1:0] job_data,
  output logic                job_pop,
  input  logic                out_take,
  output logic                out_valid,
  output fprt_pkg::out_item_t out_data
);

  localparam int STEP  = fprt_pkg::DIV_STEP;
  localparam int NCH   = (INT_BITS + STEP - 1) / STEP;
  localparam int PADW  = NCH * STEP;
  localparam int NCW   = $clog2(NCH + 1);
  localparam int CIW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int DEPTH = INT_BITS;
  localparam int AW    = $clog2(DEPTH);
  localparam int SPW   = $clog2(DEPTH + 1);
  localparam int FCW   = (FRAC_DIGITS > 1) ? $clog2(FRAC_DIGITS) : 1;
  localparam int PW    = FRAC_BITS + 6;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DIV   = 3'd1;
  localparam logic [2:0] S_PRIME = 3'd2;
  localparam logic [2:0] S_INT   = 3'd3;
  localparam logic [2:0] S_POINT = 3'd4;
  localparam logic [2:0] S_FRAC  = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic [PADW-1:0]      quo_r, quo_nxt;
  logic [5:0]           rem_r, rem_nxt;
  logic [CIW-1:0]       ci_r, ci_nxt;
  logic [NCW-1:0]       nch_r, nch_nxt;
  logic                 top_zero_r, top_zero_nxt;
  logic [5:0]           r_r, r_nxt;
  logic [FRAC_BITS-1:0] fp_r, fp_nxt;
  logic [SPW-1:0]       sp_r, sp_nxt;
  logic [FCW-1:0]       fcnt_r, fcnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  fprt_pkg::out_item_t  out_data_r, out_data_nxt;
  logic [5:0]           rd_r;
  logic [5:0]           mem [DEPTH];

  logic [PADW-1:0]      ip_j;
  logic [FRAC_BITS-1:0] fp_j;
  logic [5:0]           r_j;
  logic [NCW-1:0]       nch_j;

  logic [STEP-1:0]      chunk_in, q;
  logic [5:0]           rem_w;
  logic [6:0]           t;
  logic [PADW-1:0]      quo_w;
  logic                 new_top_zero;
  logic [NCW-1:0]       nch_n;
  logic [PW-1:0]        prod;
  logic                 can_load, out_load, wr_en, frac_last;
  logic [AW-1:0]        rd_addr;

  assign ip_j  = job_data[PADW-1:0];
  assign fp_j  = job_data[PADW +: FRAC_BITS];
  assign r_j   = job_data[PADW+FRAC_BITS +: 6];
  assign nch_j = job_data[PADW+FRAC_BITS+6 +: NCW];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign can_load  = !out_valid_r || out_take;
  assign prod      = PW'(fp_r) * PW'(r_r);
  assign frac_last = (fcnt_r == FCW'(FRAC_DIGITS - 1));

  // One dividend chunk per cycle: a short chain of restoring steps on the
  // running remainder, which never exceeds the radix.
  always_comb begin
    chunk_in = quo_r[ci_r*STEP +: STEP];
    rem_w    = rem_r;
    q        = '0;
    t        = '0;
    for (int b = STEP - 1; b >= 0; b--) begin
      t = {rem_w, chunk_in[b]};
      if (t >= {1'b0, r_r}) begin
        t    = t - {1'b0, r_r};
        q[b] = 1'b1;
      end
      rem_w = t[5:0];
    end
    quo_w = quo_r;
    quo_w[ci_r*STEP +: STEP] = q;
    new_top_zero = (ci_r == CIW'(nch_r - NCW'(1))) ? (q == '0) : top_zero_r;
    nch_n = new_top_zero ? nch_r - NCW'(1) : nch_r;
  end

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    ci_nxt        = ci_r;
    nch_nxt       = nch_r;
    top_zero_nxt  = top_zero_r;
    r_nxt         = r_r;
    fp_nxt        = fp_r;
    sp_nxt        = sp_r;
    fcnt_nxt      = fcnt_r;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    job_pop       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (job_valid) begin
          job_pop      = 1'b1;
          quo_nxt      = ip_j;
          fp_nxt       = fp_j;
          r_nxt        = r_j;
          nch_nxt      = nch_j;
          ci_nxt       = CIW'(nch_j - NCW'(1));
          rem_nxt      = '0;
          top_zero_nxt = 1'b0;
          sp_nxt       = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        quo_nxt      = quo_w;
        rem_nxt      = rem_w;
        top_zero_nxt = new_top_zero;
        if (ci_r == '0) begin
          wr_en        = 1'b1;
          sp_nxt       = sp_r + SPW'(1);
          rem_nxt      = '0;
          top_zero_nxt = 1'b0;
          if (quo_w == '0) begin
            state_nxt = S_PRIME;
          end else begin
            nch_nxt = nch_n;
            ci_nxt  = CIW'(nch_n - NCW'(1));
          end
        end else begin
          ci_nxt = ci_r - CIW'(1);
        end
      end
      S_PRIME: begin
        state_nxt = S_INT;
      end
      S_INT: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_data_nxt = '{char_code: fprt_pkg::digit_code(rd_r), last_char: 1'b0};
          sp_nxt       = sp_r - SPW'(1);
          if (sp_r == SPW'(1)) begin
            state_nxt = S_POINT;
          end
        end
      end
      S_POINT: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_data_nxt = '{char_code: fprt_pkg::CHR_POINT, last_char: 1'b0};
          fcnt_nxt     = '0;
          state_nxt    = S_FRAC;
        end
      end
      S_FRAC: begin
        if (can_load) begin
          out_load     = 1'b1;
          out_data_nxt = '{char_code: fprt_pkg::digit_code(prod[FRAC_BITS +: 6]),
                           last_char: frac_last};
          fp_nxt       = prod[FRAC_BITS-1:0];
          if (frac_last) begin
            state_nxt = S_IDLE;
          end else begin
            fcnt_nxt = fcnt_r + FCW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
    rd_addr = AW'(sp_nxt - SPW'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    ci_r       <= ci_nxt;
    nch_r      <= nch_nxt;
    top_zero_r <= top_zero_nxt;
    r_r        <= r_nxt;
    fp_r       <= fp_nxt;
    sp_r       <= sp_nxt;
    fcnt_r     <= fcnt_nxt;
    out_data_r <= out_data_nxt;
  end

  // Digit stack: integer digits are pushed least significant first and read
  // back from the top.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[sp_r[AW-1:0]] <= rem_w;
    end
    rd_r <= mem[rd_addr];
  end

endmodule

/* hw/rtl/fixed_point_to_radix_text.sv */
// Channel   Ports                        Transfer when
// --------  ---------------------------  -----------------------
// input     push, full, in_data          push high and full low
// result    empty, pop, out_data         pop high and empty low
//
// Each integer digit is found by dividing one significant byte at a time; a 32-bit integer
// part has one to four significant bytes. The back end takes a job from the queue, divides,
// then primes the digit stack; the integer digits, the point and the fraction digits then
// leave at one character per cycle while the result is not stalled. Reset is synchronous
// and active low. A two-entry queue lets new items be taken while a conversion is running,
// and a stalled result holds the back end without losing a character.
module fixed_point_to_radix_text #(
  parameter int INT_BITS    = fprt_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS   = fprt_pkg::FRAC_BITS_DEF,
  parameter int FRAC_DIGITS = fprt_pkg::FRAC_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  fprt_pkg::in_item_t  in_data,
  output logic                empty,
  input  logic                pop,
  output fprt_pkg::out_item_t out_data
);

  localparam int NCH = (INT_BITS + fprt_pkg::DIV_STEP - 1) / fprt_pkg::DIV_STEP;
  localparam int JW  = $clog2(NCH + 1) + 6 + FRAC_BITS + NCH * fprt_pkg::DIV_STEP;

  logic [JW-1:0] job_in, job_out;
  logic          q_empty, job_pop, out_valid;

  fprt_front #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .in_data (in_data),
    .job     (job_in)
  );

  fprt_queue #(
    .W (JW)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (q_empty)
  );

  fprt_back #(
    .INT_BITS    (INT_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .FRAC_DIGITS (FRAC_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job_data  (job_out),
    .job_pop   (job_pop),
    .out_take  (pop && out_valid),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign empty = !out_valid;

endmodule
